### design/bdsc_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear downscaler package
// Types and constants that the front, the job queue and the back share.
// ----------------------------------------------------------------------------
package bdsc_pkg;

   localparam int REG_W    = 20;
   localparam int DIM_W    = 12;
   localparam int COORD_W  = 11;
   localparam int PIX_W    = 8;
   localparam int FRAC_MAX = 16;
   localparam int IDX_W    = 3;

   localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
   localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
   localparam logic [IDX_W-1:0] REG_SCALE_X    = 3'd4;
   localparam logic [IDX_W-1:0] REG_SCALE_Y    = 3'd5;

   localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 12'd2048;
   localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 12'd2048;
   localparam logic [DIM_W-1:0] RST_DST_WIDTH  = 12'd1024;
   localparam logic [DIM_W-1:0] RST_DST_HEIGHT = 12'd1024;
   localparam logic [REG_W-1:0] RST_SCALE      = 20'd65536;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   typedef enum logic {
      JOB_COPY  = 1'b0,
      JOB_BLEND = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type         kind;
      logic [FRAC_MAX-1:0]  fu;
      logic [FRAC_MAX-1:0]  fv;
      logic [PIX_W-1:0]     a;
      logic [PIX_W-1:0]     b;
      logic [PIX_W-1:0]     c;
      logic [PIX_W-1:0]     d;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic                 last;
   } job_type;

endpackage

### design/bilinear_downscaler.sv
// ----------------------------------------------------------------------------
// Bilinear downscaler
// Streams 8-bit source pixels in raster order and emits downscaled pixels
// tagged with destination column and row.
// ----------------------------------------------------------------------------
// Each source request passes through the front's accept and line store read
// step, its evaluation step and a push step for every result it causes. The
// back handles one result at a time: a copied pixel goes straight to the
// output register, and a blended pixel first passes through the multiply
// steps, since its four weight products and four pixel products go through
// one shared multiplier pair in turn. A four-entry job queue lets the front
// keep taking requests while the back works off blended results.
module bilinear_downscaler #(
   parameter int MAX_LINE  = 2048,
   parameter int FRAC_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel
   input  logic [0:0]  req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_pixel, out_col, out_row, zero fill
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   import bdsc_pkg::*;

   job_type fr_job, bk_job;
   logic    fr_valid, fr_ready, bk_valid, bk_pop;

   bdsc_front #(
      .MAX_LINE  (MAX_LINE),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .job_valid  (fr_valid),
      .job        (fr_job),
      .job_ready  (fr_ready)
   );

   bdsc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_job   (fr_job),
      .rd_valid (bk_valid),
      .rd_ready (bk_pop),
      .rd_job   (bk_job)
   );

   bdsc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (bk_valid),
      .job_pop    (bk_pop),
      .job        (bk_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/bdsc_front.sv
// ----------------------------------------------------------------------------
// Bilinear downscaler front
// Accepts source pixels, keeps the line store and the position state, and
// turns each pixel into up to three result jobs for the back.
// ----------------------------------------------------------------------------
module bdsc_front #(
   parameter int MAX_LINE  = 2048,
   parameter int FRAC_BITS = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic [0:0]        req_tuser,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [19:0]       csr_wdata,
   output logic              job_valid,
   output bdsc_pkg::job_type job,
   input  logic              job_ready
);
   import bdsc_pkg::*;

   localparam int AW    = $clog2(MAX_LINE);
   localparam int POS_W = FRAC_BITS + 13;
   localparam int IP_W  = POS_W - FRAC_BITS;
   localparam int LY_W  = 33;
   localparam int LR_W  = LY_W - FRAC_BITS;
   localparam logic [POS_W-1:0] HALF_POS   = POS_W'(1) << (FRAC_BITS - 1);
   localparam logic [LY_W-1:0]  HALF_LY    = LY_W'(1) << (FRAC_BITS - 1);
   localparam logic [REG_W-1:0] ONE_POS    = REG_W'(1) << FRAC_BITS;
   localparam logic [13:0]      MAX_LINE_W = 14'(MAX_LINE);
   localparam logic [AW-1:0]    LAST_COL   = AW'(MAX_LINE - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EVAL = 3'b010,
      S_PUSH = 3'b100
   } state_type;

   state_type          state_ff;
   logic [DIM_W-1:0]   sw_reg_ff, sh_reg_ff, dw_reg_ff, dh_reg_ff;
   logic [REG_W-1:0]   sx_reg_ff, sy_reg_ff;
   logic [LY_W-2:0]    prod_ff;
   logic [PIX_W-1:0]   line_mem [MAX_LINE];
   logic [PIX_W-1:0]   rd_ff, pix_ff, left_ff, ul_ff;
   logic [AW-1:0]      src_col_ff, col_ff;
   logic [DIM_W-1:0]   src_row_ff, dc_ff, dr_ff, lc_ff;
   logic [POS_W-1:0]   y_ff, x_ff, lx_ff;
   job_type            jobs_ff [3];
   logic [2:0]         pend_ff;

   logic [13:0]        sw;
   logic [DIM_W-1:0]   sh, dw, dh;
   logic [REG_W-1:0]   sx, sy;
   logic               accept;
   logic [AW-1:0]      col_acc;
   logic [IP_W-1:0]    xi, yi, col_ip;
   logic               interior, e1, e2, e3, eol;
   logic [POS_W-1:0]   x1, x2;
   logic [DIM_W-1:0]   dc1, dc2;
   logic [LY_W-1:0]    ly;
   logic [1:0]         sel;
   logic [2:0]         pend_left;
   job_type            j1, j2, j3;

   always_comb begin
      sw = (sw_reg_ff == '0) ? 14'd1 : {2'b00, sw_reg_ff};
      if (sw > MAX_LINE_W) begin
         sw = MAX_LINE_W;
      end
      sh = (sh_reg_ff == '0) ? 12'd1 : sh_reg_ff;
      dw = (dw_reg_ff == '0) ? 12'd1 : dw_reg_ff;
      dh = (dh_reg_ff == '0) ? 12'd1 : dh_reg_ff;
      sx = (sx_reg_ff < ONE_POS) ? ONE_POS : sx_reg_ff;
      sy = (sy_reg_ff < ONE_POS) ? ONE_POS : sy_reg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_reg_ff <= RST_SRC_WIDTH;
         sh_reg_ff <= RST_SRC_HEIGHT;
         dw_reg_ff <= RST_DST_WIDTH;
         dh_reg_ff <= RST_DST_HEIGHT;
         sx_reg_ff <= RST_SCALE;
         sy_reg_ff <= RST_SCALE;
      end else if (csr_we) begin
         case (csr_index)
            REG_SRC_WIDTH:  sw_reg_ff <= csr_wdata[DIM_W-1:0];
            REG_SRC_HEIGHT: sh_reg_ff <= csr_wdata[DIM_W-1:0];
            REG_DST_WIDTH:  dw_reg_ff <= csr_wdata[DIM_W-1:0];
            REG_DST_HEIGHT: dh_reg_ff <= csr_wdata[DIM_W-1:0];
            REG_SCALE_X:    sx_reg_ff <= csr_wdata;
            REG_SCALE_Y:    sy_reg_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= (LY_W - 1)'(dh - 12'd1) * (LY_W - 1)'(sy);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_acc = req_tuser[0] ? '0 : src_col_ff;
      if (col_acc > LAST_COL) begin
         col_acc = LAST_COL;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         line_mem[col_ff] <= pix_ff;
      end
      if (accept) begin
         rd_ff <= line_mem[col_acc];
      end
   end

   always_comb begin
      xi       = x_ff[POS_W-1:FRAC_BITS];
      yi       = y_ff[POS_W-1:FRAC_BITS];
      col_ip   = IP_W'(col_ff);
      interior = (13'(dr_ff) + 13'd1 < 13'(dh)) &&
                 (IP_W'(src_row_ff) == yi + IP_W'(1));
      e1  = interior && (13'(dc_ff) + 13'd1 < 13'(dw)) && (xi + IP_W'(1) == col_ip);
      x1  = e1 ? x_ff + POS_W'(sx) : x_ff;
      dc1 = dc_ff + DIM_W'(e1);
      e2  = interior && (13'(dc1) + 13'd1 == 13'(dw)) &&
            (x1[POS_W-1:FRAC_BITS] == col_ip);
      x2  = e2 ? x1 + POS_W'(sx) : x1;
      dc2 = dc1 + DIM_W'(e2);
      ly  = {1'b0, prod_ff} + HALF_LY;
      e3  = (LR_W'(src_row_ff) == ly[LY_W-1:FRAC_BITS]) && (lc_ff < dw) &&
            (lx_ff[POS_W-1:FRAC_BITS] == col_ip);
      eol = (14'(col_ff) + 14'd1 >= sw);

      j1      = '0;
      j1.kind = JOB_BLEND;
      j1.fu   = FRAC_MAX'(x_ff[FRAC_BITS-1:0]);
      j1.fv   = FRAC_MAX'(y_ff[FRAC_BITS-1:0]);
      j1.a    = ul_ff;
      j1.b    = rd_ff;
      j1.c    = left_ff;
      j1.d    = pix_ff;
      j1.col  = dc_ff[COORD_W-1:0];
      j1.row  = dr_ff[COORD_W-1:0];
      j1.last = !e2 && !e3;

      j2      = '0;
      j2.kind = JOB_COPY;
      j2.a    = rd_ff;
      j2.col  = dc1[COORD_W-1:0];
      j2.row  = dr_ff[COORD_W-1:0];
      j2.last = !e3;

      j3      = '0;
      j3.kind = JOB_COPY;
      j3.a    = pix_ff;
      j3.col  = lc_ff[COORD_W-1:0];
      j3.row  = COORD_W'(dh - 12'd1);
      j3.last = 1'b1;
   end

   always_comb begin
      if (pend_ff[0]) begin
         sel = 2'd0;
      end else if (pend_ff[1]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
      pend_left = pend_ff & ~(3'b001 << sel);
   end

   assign job_valid = (state_ff == S_PUSH);
   assign job       = jobs_ff[sel];

   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         jobs_ff[0] <= j1;
         jobs_ff[1] <= j2;
         jobs_ff[2] <= j3;
         ul_ff      <= rd_ff;
         left_ff    <= pix_ff;
      end
      if (accept) begin
         pix_ff <= req_tdata;
         col_ff <= col_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pend_ff    <= '0;
         src_col_ff <= '0;
         src_row_ff <= '0;
         y_ff       <= HALF_POS;
         x_ff       <= HALF_POS;
         lx_ff      <= HALF_POS;
         dc_ff      <= '0;
         dr_ff      <= '0;
         lc_ff      <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_tuser[0]) begin
                     src_row_ff <= '0;
                     y_ff       <= HALF_POS;
                     x_ff       <= HALF_POS;
                     lx_ff      <= HALF_POS;
                     dc_ff      <= '0;
                     dr_ff      <= '0;
                     lc_ff      <= '0;
                  end
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               pend_ff  <= {e3, e2, e1};
               state_ff <= (e1 || e2 || e3) ? S_PUSH : S_IDLE;
               if (eol) begin
                  x_ff       <= HALF_POS;
                  dc_ff      <= '0;
                  lx_ff      <= HALF_POS;
                  lc_ff      <= '0;
                  src_col_ff <= '0;
                  if (13'(src_row_ff) + 13'd1 >= 13'(sh)) begin
                     src_row_ff <= '0;
                     y_ff       <= HALF_POS;
                     dr_ff      <= '0;
                  end else begin
                     src_row_ff <= src_row_ff + 12'd1;
                     if (interior) begin
                        dr_ff <= dr_ff + 12'd1;
                        y_ff  <= y_ff + POS_W'(sy);
                     end
                  end
               end else begin
                  src_col_ff <= col_ff + AW'(1);
                  x_ff       <= x2;
                  dc_ff      <= dc2;
                  lx_ff      <= e3 ? lx_ff + POS_W'(sx) : lx_ff;
                  lc_ff      <= lc_ff + DIM_W'(e3);
               end
            end
            S_PUSH: begin
               if (job_ready) begin
                  pend_ff <= pend_left;
                  if (pend_left == '0) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

### design/bdsc_fifo.sv
// ----------------------------------------------------------------------------
// Bilinear downscaler job queue
// Short first-in first-out queue of result jobs between front and back.
// ----------------------------------------------------------------------------
module bdsc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  bdsc_pkg::job_type wr_job,
   output logic              rd_valid,
   input  logic              rd_ready,
   output bdsc_pkg::job_type rd_job
);
   import bdsc_pkg::*;

   job_type     slots_ff [4];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  count_ff;
   logic        push, pop;

   assign wr_ready = (count_ff != 3'd4);
   assign rd_valid = (count_ff != 3'd0);
   assign rd_job   = slots_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + 3'(push) - 3'(pop);
      end
   end

endmodule

### design/bdsc_back.sv
// ----------------------------------------------------------------------------
// Bilinear downscaler back
// Takes jobs from the queue, forms the weighted blend with one shared
// multiplier pair, and holds each result in the output register.
// ----------------------------------------------------------------------------
module bdsc_back #(
   parameter int FRAC_BITS = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_pop,
   input  bdsc_pkg::job_type job,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic              rsp_tlast
);
   import bdsc_pkg::*;

   localparam int W_W   = 2 * FRAC_BITS;
   localparam int ACC_W = 2 * FRAC_BITS + 10;
   localparam logic [FRAC_BITS-1:0] FRAC_ONES = '1;
   localparam logic [ACC_W-1:0]     ROUND     = ACC_W'(1) << (W_W - 1);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_MUL  = 3'b010,
      B_OUT  = 3'b100
   } state_type;

   state_type         state_ff;
   job_type           job_ff;
   logic [2:0]        step_ff;
   logic [W_W-1:0]    w_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic              tvalid_ff, tlast_ff;
   logic [31:0]       tdata_ff;

   logic [FRAC_BITS-1:0] fu, fv, wa, wb;
   logic [PIX_W-1:0]     p_sel, res_pix;
   logic [9:0]           acc_top;
   logic                 load;

   always_comb begin
      fu = job_ff.fu[FRAC_BITS-1:0];
      fv = job_ff.fv[FRAC_BITS-1:0];
      case (step_ff)
         3'd0: begin
            wa = FRAC_ONES - fu;
            wb = FRAC_ONES - fv;
         end
         3'd1: begin
            wa = fu;
            wb = FRAC_ONES - fv;
         end
         3'd2: begin
            wa = FRAC_ONES - fu;
            wb = fv;
         end
         default: begin
            wa = fu;
            wb = fv;
         end
      endcase
      case (step_ff)
         3'd1:    p_sel = job_ff.a;
         3'd2:    p_sel = job_ff.b;
         3'd3:    p_sel = job_ff.c;
         default: p_sel = job_ff.d;
      endcase
      acc_top = acc_ff[ACC_W-1:W_W];
      if (job_ff.kind == JOB_COPY) begin
         res_pix = job_ff.a;
      end else if (acc_top > 10'(PIX_MAX)) begin
         res_pix = PIX_MAX;
      end else begin
         res_pix = acc_top[PIX_W-1:0];
      end
   end

   assign job_pop    = (state_ff == B_IDLE) && job_valid;
   assign load       = (state_ff == B_OUT) && (!tvalid_ff || rsp_tready);
   assign rsp_tvalid = tvalid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tlast  = tlast_ff;

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job;
         acc_ff <= ROUND;
      end
      if (state_ff == B_MUL) begin
         if (step_ff != 3'd4) begin
            w_ff <= W_W'(wa) * W_W'(wb);
         end
         if (step_ff != 3'd0) begin
            acc_ff <= acc_ff + ACC_W'(w_ff) * ACC_W'(p_sel);
         end
      end
      if (load) begin
         tdata_ff <= {2'b00, job_ff.row, job_ff.col, res_pix};
         tlast_ff <= job_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         step_ff   <= '0;
         tvalid_ff <= 1'b0;
      end else begin
         if (load) begin
            tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            tvalid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               step_ff <= '0;
               if (job_valid) begin
                  state_ff <= (job.kind == JOB_BLEND) ? B_MUL : B_OUT;
               end
            end
            B_MUL: begin
               if (step_ff == 3'd4) begin
                  state_ff <= B_OUT;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            B_OUT: begin
               if (load) begin
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule

### design/bdsc_checker.sv
// ----------------------------------------------------------------------------
// Bilinear downscaler checker
// Port-level properties of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module bdsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("front took a request while still evaluating one");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:30] == 2'b00)
      else $error("result fill bits not zero");

endmodule

bind bilinear_downscaler bdsc_checker u_bdsc_checker (.*);

### test/bilinear_downscaler_tb.sv
// ----------------------------------------------------------------------------
// Bilinear downscaler testbench
// Streams directed and random source frames through the downscaler under
// several register settings and checks every destination pixel, its column,
// its row and its last flag against a cycle-free model of the same blend.
// ----------------------------------------------------------------------------
module bilinear_downscaler_tb;
   import bdsc_pkg::*;

   localparam int FRAC       = 15;
   localparam int LINE_DEPTH = 2048;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE     = 30;

   typedef struct {
      bit [7:0]  pix;
      bit [10:0] col;
      bit [10:0] row;
      bit        last;
   } dst_sample_type;

   typedef struct {
      int       setting;
      bit [7:0] pix;
      bit       frame_start;
      bit       typed;
      bit [7:0] typed_pix;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [19:0] csr_wdata;

   dst_sample_type expected_pixels[$];
   int          error_count;
   int          idle_cycles;

   bit [19:0]   reg_file[6];
   bit [7:0]    line_mem[LINE_DEPTH];
   bit [10:0]   cur_col, cur_row, out_col_cnt, out_row_cnt, bottom_col_cnt;
   bit [47:0]   pos_y, pos_x, bottom_pos_x;
   bit [7:0]    left_pix, upper_left_pix;

   bilinear_downscaler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void restart_positions();
      cur_col = '0;
      cur_row = '0;
      pos_y = 48'd16384;
      pos_x = 48'd16384;
      bottom_pos_x = 48'd16384;
      out_col_cnt = '0;
      out_row_cnt = '0;
      bottom_col_cnt = '0;
   endfunction

   function automatic bit [47:0] floor_of(bit [19:0] v, bit [47:0] lo);
      return (v < lo) ? lo : 48'(v);
   endfunction

   function automatic void push_pixel(bit [47:0] v, bit [10:0] c, bit [10:0] r);
      dst_sample_type s;
      s.pix = v[7:0];
      s.col = c;
      s.row = r;
      s.last = 1'b0;
      expected_pixels.push_back(s);
   endfunction

   function automatic bit [47:0] mix(bit [47:0] fu, bit [47:0] fv, bit [47:0] a,
                                     bit [47:0] b, bit [47:0] c, bit [47:0] d);
      bit [47:0] m;
      bit [47:0] s;
      m = 48'd32767;
      s = (m - fu) * (m - fv) * a + fu * (m - fv) * b + (m - fu) * fv * c
          + fu * fv * d + (48'd1 << (2 * FRAC - 1));
      s = s >> (2 * FRAC);
      return (s > 48'd255) ? 48'd255 : s;
   endfunction

   // Works out the destination pixels that one source request causes.
   function automatic void downscale_step(bit [7:0] pix, bit frame_start);
      bit [47:0] sw, sh, dw, dh, sx, sy, bottom_y, v;
      bit [10:0] col;
      bit [7:0]  above;
      bit        interior;
      int        first;
      first = expected_pixels.size();
      sw = floor_of(reg_file[REG_SRC_WIDTH], 48'd1);
      if (sw > LINE_DEPTH) sw = 48'(LINE_DEPTH);
      sh = floor_of(reg_file[REG_SRC_HEIGHT], 48'd1);
      dw = floor_of(reg_file[REG_DST_WIDTH], 48'd1);
      dh = floor_of(reg_file[REG_DST_HEIGHT], 48'd1);
      sx = floor_of(reg_file[REG_SCALE_X], 48'd32768);
      sy = floor_of(reg_file[REG_SCALE_Y], 48'd32768);
      if (frame_start) restart_positions();
      col = cur_col;
      above = line_mem[col];
      interior = (48'(out_row_cnt) + 1 < dh) && (48'(cur_row) == (pos_y >> FRAC) + 1);
      if (interior) begin
         if (48'(out_col_cnt) + 1 < dw && (pos_x >> FRAC) + 1 == 48'(col)) begin
            v = mix(48'(pos_x[14:0]), 48'(pos_y[14:0]), 48'(upper_left_pix), 48'(above),
                    48'(left_pix), 48'(pix));
            push_pixel(v, out_col_cnt, out_row_cnt);
            out_col_cnt++;
            pos_x += sx;
         end
         if (48'(out_col_cnt) + 1 == dw && (pos_x >> FRAC) == 48'(col)) begin
            push_pixel(48'(above), out_col_cnt, out_row_cnt);
            out_col_cnt++;
            pos_x += sx;
         end
      end
      bottom_y = 48'd16384 + (dh - 1) * sy;
      if (48'(cur_row) == (bottom_y >> FRAC) && 48'(bottom_col_cnt) < dw &&
          (bottom_pos_x >> FRAC) == 48'(col)) begin
         push_pixel(48'(pix), bottom_col_cnt, 11'(dh - 1));
         bottom_col_cnt++;
         bottom_pos_x += sx;
      end
      upper_left_pix = above;
      line_mem[col] = pix;
      left_pix = pix;
      if (48'(col) + 1 >= sw) begin
         if (interior) begin
            out_row_cnt++;
            pos_y += sy;
         end
         pos_x = 48'd16384;
         out_col_cnt = '0;
         bottom_pos_x = 48'd16384;
         bottom_col_cnt = '0;
         cur_col = '0;
         if (48'(cur_row) + 1 >= sh) restart_positions();
         else cur_row++;
      end else begin
         cur_col = col + 11'd1;
      end
      if (expected_pixels.size() > first) expected_pixels[$].last = 1'b1;
   endfunction

   task automatic send_request(bit [7:0] pix, bit frame_start);
      int gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= frame_start;
      do @(posedge clock); while (!req_tready);
      downscale_step(pix, frame_start);
   endtask

   task automatic program_regs(bit [19:0] vals[6]);
      req_tvalid <= 1'b0;
      wait (expected_pixels.size() == 0);
      repeat (SETTLE) @(posedge clock);
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         reg_file[i] = vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic int frame_length();
      int sw, sh;
      sw = (reg_file[REG_SRC_WIDTH] == 0) ? 1 : int'(reg_file[REG_SRC_WIDTH]);
      if (sw > LINE_DEPTH) sw = LINE_DEPTH;
      sh = (reg_file[REG_SRC_HEIGHT] == 0) ? 1 : int'(reg_file[REG_SRC_HEIGHT]);
      return sw * sh;
   endfunction

   function automatic bit [7:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // Response side: random back-pressure with stretches of none.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      dst_sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result pixel=%0d col=%0d row=%0d", rsp_tdata[7:0],
                   rsp_tdata[18:8], rsp_tdata[29:19]);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== want.pix) begin
               $error("out_pixel expected %0d actual %0d", want.pix, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[18:8] !== want.col) begin
               $error("out_col expected %0d actual %0d", want.col, rsp_tdata[18:8]);
               error_count++;
            end
            if (rsp_tdata[29:19] !== want.row) begin
               $error("out_row expected %0d actual %0d", want.row, rsp_tdata[29:19]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("run_last expected %0d actual %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("bilinear_downscaler_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      bit [19:0]     settings[3][6];
      bit [19:0]     vals[6];
      directed_row_type plan[$];
      int            current, random_items, len, frames;
      dst_sample_type typed_result;

      // Small sizes with scales below their floor, a bilinear 2:1 case, and a
      // long line with the largest column step.
      settings[0] = '{20'd2, 20'd2, 20'd1, 20'd1, 20'd0, 20'd0};
      settings[1] = '{20'd4, 20'd4, 20'd2, 20'd2, 20'd65536, 20'd65536};
      settings[2] = '{20'd70, 20'd2, 20'd3, 20'd2, 20'hFFFFF, 20'd0};
      plan = '{
         '{0, 8'd255, 1'b1, 1'b1, 8'd255}, '{0, 8'd0, 1'b0, 1'b0, 8'd0},
         '{0, 8'd17, 1'b0, 1'b0, 8'd0},    '{0, 8'd200, 1'b0, 1'b0, 8'd0},
         '{0, 8'd0, 1'b0, 1'b1, 8'd0},     '{0, 8'd9, 1'b0, 1'b0, 8'd0},
         '{0, 8'd128, 1'b1, 1'b1, 8'd128}, '{0, 8'd1, 1'b0, 1'b0, 8'd0},
         '{1, 8'd255, 1'b1, 1'b0, 8'd0},   '{1, 8'd0, 1'b0, 1'b0, 8'd0},
         '{1, 8'd255, 1'b0, 1'b0, 8'd0},   '{1, 8'd0, 1'b0, 1'b0, 8'd0},
         '{1, 8'd0, 1'b0, 1'b0, 8'd0},     '{1, 8'd255, 1'b0, 1'b0, 8'd0},
         '{1, 8'd0, 1'b0, 1'b0, 8'd0},     '{1, 8'd255, 1'b0, 1'b0, 8'd0},
         '{1, 8'd255, 1'b0, 1'b0, 8'd0},   '{1, 8'd255, 1'b0, 1'b0, 8'd0},
         '{1, 8'd255, 1'b0, 1'b0, 8'd0},   '{1, 8'd255, 1'b0, 1'b0, 8'd0},
         '{1, 8'd85, 1'b0, 1'b0, 8'd0},    '{1, 8'd170, 1'b0, 1'b0, 8'd0},
         '{1, 8'd51, 1'b0, 1'b0, 8'd0},    '{1, 8'd204, 1'b0, 1'b0, 8'd0}
      };

      error_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reg_file = '{20'(RST_SRC_WIDTH), 20'(RST_SRC_HEIGHT), 20'(RST_DST_WIDTH),
                   20'(RST_DST_HEIGHT), RST_SCALE, RST_SCALE};
      foreach (line_mem[i]) line_mem[i] = '0;
      left_pix = '0;
      upper_left_pix = '0;
      restart_positions();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      current = -1;
      foreach (plan[i]) begin
         if (plan[i].setting != current) begin
            current = plan[i].setting;
            program_regs(settings[current]);
         end
         send_request(plan[i].pix, plan[i].frame_start);
         if (plan[i].typed) begin
            void'(expected_pixels.pop_back());
            typed_result = '{plan[i].typed_pix, 11'd0, 11'd0, 1'b1};
            expected_pixels.push_back(typed_result);
         end
      end

      program_regs(settings[2]);
      len = frame_length();
      for (int k = 0; k < len; k++) send_request(random_pixel(), k == 0);

      random_items = 0;
      while (random_items < 180) begin
         vals[REG_SRC_WIDTH] = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 1))
                                                           : 20'($urandom_range(2, 12));
         vals[REG_SRC_HEIGHT] = 20'($urandom_range(0, 8));
         vals[REG_DST_WIDTH] = 20'($urandom_range(0, 9));
         vals[REG_DST_HEIGHT] = 20'($urandom_range(0, 6));
         vals[REG_SCALE_X] = ($urandom_range(0, 9) == 0) ? 20'hFFFFF
                                                         : 20'($urandom_range(0, 4 * 32768));
         vals[REG_SCALE_Y] = ($urandom_range(0, 9) == 0) ? 20'hFFFFF
                                                         : 20'($urandom_range(0, 4 * 32768));
         program_regs(vals);
         len = frame_length();
         frames = $urandom_range(1, 3);
         for (int k = 0; k < len * frames; k++) begin
            send_request(random_pixel(), k == 0 || $urandom_range(0, 40) == 0);
            random_items++;
         end
      end

      req_tvalid <= 1'b0;
      wait (expected_pixels.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("bilinear_downscaler_tb: PASS");
      end else begin
         $display("bilinear_downscaler_tb: FAIL");
      end
      $finish;
   end

endmodule

### bilinear_downscaler.f
design/bdsc_pkg.sv
design/bdsc_front.sv
design/bdsc_fifo.sv
design/bdsc_back.sv
design/bilinear_downscaler.sv
design/bdsc_checker.sv
test/bilinear_downscaler_tb.sv
